>>> src/stt_pkg.sv
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared result types, token codes and character class helpers.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Token kinds
  localparam logic [4:0] TK_EOF        = 5'd0;
  localparam logic [4:0] TK_NUMBER     = 5'd1;
  localparam logic [4:0] TK_BOOLEAN    = 5'd2;
  localparam logic [4:0] TK_KEYWORD    = 5'd3;
  localparam logic [4:0] TK_IDENT      = 5'd4;
  localparam logic [4:0] TK_STRING     = 5'd5;
  localparam logic [4:0] TK_OP_PLUS    = 5'd6;
  localparam logic [4:0] TK_OP_MINUS   = 5'd7;
  localparam logic [4:0] TK_OP_STAR    = 5'd8;
  localparam logic [4:0] TK_OP_SLASH   = 5'd9;
  localparam logic [4:0] TK_OP_PERCENT = 5'd10;
  localparam logic [4:0] TK_OP_LPAREN  = 5'd11;
  localparam logic [4:0] TK_OP_RPAREN  = 5'd12;
  localparam logic [4:0] TK_OP_ASSIGN  = 5'd13;
  localparam logic [4:0] TK_OP_COLON   = 5'd14;
  localparam logic [4:0] TK_OP_COMMA   = 5'd15;
  localparam logic [4:0] TK_OP_LBRACE  = 5'd16;
  localparam logic [4:0] TK_OP_RBRACE  = 5'd17;
  localparam logic [4:0] TK_OP_SEMI    = 5'd18;
  localparam logic [4:0] TK_ERROR      = 5'd19;
  localparam logic [4:0] TK_STR_BYTE   = 5'd20;

  // Error codes
  localparam logic [30:0] ERR_BAD_ESCAPE   = 31'd0;
  localparam logic [30:0] ERR_UNTERMINATED = 31'd1;
  localparam logic [30:0] ERR_TOO_LONG     = 31'd2;
  localparam logic [30:0] ERR_UNEXPECTED   = 31'd3;

  localparam logic [30:0] ACC_MAX  = 31'h7FFF_FFFF;
  localparam int          KW_COUNT = 7;

  // Result queue geometry
  localparam int QDEPTH = 8;
  localparam int QAW    = 3;
  localparam int QCW    = 4;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [30:0] value;
    logic [31:0] start_offset;
    logic [15:0] span_length;
    logic [31:0] line_number;
    logic        last;
  } result_t;

  // Up to three results written into the queue in one cycle
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     res;
  } rq_write_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // Operator token for a byte, TK_EOF when the byte is no operator
  function automatic logic [4:0] op_kind(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      "+":     k = TK_OP_PLUS;
      "-":     k = TK_OP_MINUS;
      "*":     k = TK_OP_STAR;
      "/":     k = TK_OP_SLASH;
      "%":     k = TK_OP_PERCENT;
      "(":     k = TK_OP_LPAREN;
      ")":     k = TK_OP_RPAREN;
      "=":     k = TK_OP_ASSIGN;
      ":":     k = TK_OP_COLON;
      ",":     k = TK_OP_COMMA;
      "{":     k = TK_OP_LBRACE;
      "}":     k = TK_OP_RBRACE;
      ";":     k = TK_OP_SEMI;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  // Word list: true, false, impl, if, else, while, for
  function automatic logic [2:0] kw_len(input logic [2:0] w);
    logic [2:0] l;
    unique case (w)
      3'd0:    l = 3'd4;
      3'd1:    l = 3'd5;
      3'd2:    l = 3'd4;
      3'd3:    l = 3'd2;
      3'd4:    l = 3'd4;
      3'd5:    l = 3'd5;
      3'd6:    l = 3'd3;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] w, input logic [2:0] p);
    logic [39:0] s;
    logic [7:0]  c;
    unique case (w)
      3'd0:    s = {"true", 8'h00};
      3'd1:    s = "false";
      3'd2:    s = {"impl", 8'h00};
      3'd3:    s = {"if", 24'h0};
      3'd4:    s = {"else", 8'h00};
      3'd5:    s = "while";
      3'd6:    s = {"for", 16'h0};
      default: s = 40'h0;
    endcase
    unique case (p)
      3'd0:    c = s[39:32];
      3'd1:    c = s[31:24];
      3'd2:    c = s[23:16];
      3'd3:    c = s[15:8];
      3'd4:    c = s[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Words still matching after byte b at position pos
  function automatic logic [KW_COUNT-1:0] kw_match(input logic [7:0] b,
                                                  input logic [15:0] pos);
    logic [KW_COUNT-1:0] m;
    for (int i = 0; i < KW_COUNT; i++) begin
      m[i] = (pos < {13'd0, kw_len(3'(i))}) && (kw_char(3'(i), pos[2:0]) == b);
    end
    return m;
  endfunction

endpackage

>>> src/stt_scanner.sv
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Input register, scan state and the per-byte token logic.
// ----------------------------------------------------------------------------
module stt_scanner #(
  parameter int STRING_LIMIT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_kind_i,
  input  logic [7:0]         in_byte_i,
  output logic               in_ready_o,
  input  logic               room_i,
  output stt_pkg::rq_write_t wr_o
);

  localparam int SCW = $clog2(STRING_LIMIT + 1);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_NUM  = 3'd1;
  localparam logic [2:0] M_DOT  = 3'd2;
  localparam logic [2:0] M_FRAC = 3'd3;
  localparam logic [2:0] M_WORD = 3'd4;
  localparam logic [2:0] M_STR  = 3'd5;
  localparam logic [2:0] M_ESC  = 3'd6;

  logic        in_v_q, in_v_d;
  logic        kind_q;
  logic [7:0]  byte_q;
  logic        proc;

  logic [2:0]                    mode_q, mode_d;
  logic [30:0]                   acc_q, acc_d;
  logic [stt_pkg::KW_COUNT-1:0]  cand_q, cand_d;
  logic [31:0]                   off_q, off_d;
  logic [31:0]                   line_q, line_d;
  logic [31:0]                   tstart_q, tstart_d;
  logic [15:0]                   tspan_q, tspan_d;
  logic [SCW-1:0]                scount_q, scount_d;

  function automatic logic [15:0] span_inc(input logic [15:0] s);
    return (s == 16'hFFFF) ? s : s + 16'd1;
  endfunction

  function automatic stt_pkg::result_t mk(input logic [4:0] k, input logic [30:0] v,
                                          input logic [31:0] st, input logic [15:0] sp,
                                          input logic [31:0] ln);
    stt_pkg::result_t r;
    r.token_kind   = k;
    r.value        = v;
    r.start_offset = st;
    r.span_length  = sp;
    r.line_number  = ln;
    r.last         = 1'b0;
    return r;
  endfunction

  // Token for a finished letter run: boolean, keyword or identifier
  function automatic stt_pkg::result_t word_tok(input logic [stt_pkg::KW_COUNT-1:0] c,
                                                input logic [15:0] sp,
                                                input logic [31:0] st,
                                                input logic [31:0] ln);
    stt_pkg::result_t r;
    logic             hit;
    r   = mk(stt_pkg::TK_IDENT, 31'd0, st, sp, ln);
    hit = 1'b0;
    for (int i = 0; i < stt_pkg::KW_COUNT; i++) begin
      if (!hit && c[i] && (sp == {13'd0, stt_pkg::kw_len(3'(i))})) begin
        hit = 1'b1;
        if (i == 0) begin
          r.token_kind = stt_pkg::TK_BOOLEAN;
          r.value      = 31'd1;
        end else if (i == 1) begin
          r.token_kind = stt_pkg::TK_BOOLEAN;
          r.value      = 31'd0;
        end else begin
          r.token_kind = stt_pkg::TK_KEYWORD;
          r.value      = 31'(i - 2);
        end
      end
    end
    return r;
  endfunction

  assign proc       = in_v_q && room_i;
  assign in_ready_o = !in_v_q || room_i;

  always_comb begin
    in_v_d = in_v_q;
    if (in_valid_i && in_ready_o) begin
      in_v_d = 1'b1;
    end else if (proc) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= in_kind_i;
      byte_q <= in_byte_i;
    end
  end

  // Token logic for the registered item
  always_comb begin
    logic [1:0]  n;
    logic        idle_go;
    logic [15:0] sp;
    logic [34:0] prod;
    logic [4:0]  opk;
    logic [7:0]  esc;
    logic        esc_ok;

    n       = 2'd0;
    idle_go = 1'b0;
    sp      = span_inc(tspan_q);
    prod    = 35'(acc_q) * 35'd10 + 35'(byte_q[3:0]);
    opk     = stt_pkg::op_kind(byte_q);
    esc     = 8'h00;
    esc_ok  = 1'b1;
    unique case (byte_q)
      "n":     esc = 8'h0A;
      "t":     esc = 8'h09;
      8'h22:   esc = 8'h22;
      8'h5C:   esc = 8'h5C;
      default: esc_ok = 1'b0;
    endcase

    wr_o.res = '0;
    mode_d   = mode_q;
    acc_d    = acc_q;
    cand_d   = cand_q;
    off_d    = off_q;
    line_d   = line_q;
    tstart_d = tstart_q;
    tspan_d  = tspan_q;
    scount_d = scount_q;

    if (proc) begin
      off_d = off_q + 32'd1;
      if (kind_q) begin
        unique case (mode_q) inside
          M_NUM, M_FRAC: begin
            wr_o.res[n] = mk(stt_pkg::TK_NUMBER, acc_q, tstart_q, tspan_q, line_q);
            n = n + 2'd1;
          end
          M_DOT: begin
            wr_o.res[n] = mk(stt_pkg::TK_NUMBER, acc_q, tstart_q, tspan_q, line_q);
            n = n + 2'd1;
            wr_o.res[n] = mk(stt_pkg::TK_ERROR, stt_pkg::ERR_UNEXPECTED, off_q - 32'd1,
                             16'd1, line_q);
            n = n + 2'd1;
          end
          M_WORD: begin
            wr_o.res[n] = word_tok(cand_q, tspan_q, tstart_q, line_q);
            n = n + 2'd1;
          end
          M_STR, M_ESC: begin
            wr_o.res[n] = mk(stt_pkg::TK_ERROR, stt_pkg::ERR_UNTERMINATED, tstart_q,
                             tspan_q, line_q);
            n = n + 2'd1;
          end
          default: ;
        endcase
        wr_o.res[n] = mk(stt_pkg::TK_EOF, 31'd0, off_q, 16'd0, line_q);
        n = n + 2'd1;
        // A fresh stream follows
        mode_d   = M_IDLE;
        acc_d    = 31'd0;
        cand_d   = '1;
        off_d    = 32'd0;
        line_d   = 32'd1;
        tstart_d = 32'd0;
        tspan_d  = 16'd0;
        scount_d = '0;
      end else begin
        unique case (mode_q)
          M_NUM: begin
            if (stt_pkg::is_digit(byte_q)) begin
              acc_d   = (prod > 35'(stt_pkg::ACC_MAX)) ? stt_pkg::ACC_MAX : prod[30:0];
              tspan_d = sp;
            end else if (byte_q == ".") begin
              mode_d = M_DOT;
            end else begin
              wr_o.res[n] = mk(stt_pkg::TK_NUMBER, acc_q, tstart_q, tspan_q, line_q);
              n = n + 2'd1;
              idle_go = 1'b1;
            end
          end
          M_DOT: begin
            if (stt_pkg::is_digit(byte_q)) begin
              mode_d  = M_FRAC;
              tspan_d = span_inc(sp);
            end else begin
              wr_o.res[n] = mk(stt_pkg::TK_NUMBER, acc_q, tstart_q, tspan_q, line_q);
              n = n + 2'd1;
              wr_o.res[n] = mk(stt_pkg::TK_ERROR, stt_pkg::ERR_UNEXPECTED, off_q - 32'd1,
                               16'd1, line_q);
              n = n + 2'd1;
              idle_go = 1'b1;
            end
          end
          M_FRAC: begin
            if (stt_pkg::is_digit(byte_q)) begin
              tspan_d = sp;
            end else begin
              wr_o.res[n] = mk(stt_pkg::TK_NUMBER, acc_q, tstart_q, tspan_q, line_q);
              n = n + 2'd1;
              idle_go = 1'b1;
            end
          end
          M_WORD: begin
            if (stt_pkg::is_alpha(byte_q)) begin
              cand_d  = cand_q & stt_pkg::kw_match(byte_q, tspan_q);
              tspan_d = sp;
            end else begin
              wr_o.res[n] = word_tok(cand_q, tspan_q, tstart_q, line_q);
              n = n + 2'd1;
              idle_go = 1'b1;
            end
          end
          M_STR: begin
            tspan_d = sp;
            if (byte_q == 8'h22) begin
              wr_o.res[n] = mk(stt_pkg::TK_STRING, 31'(scount_q), tstart_q, sp, line_q);
              n = n + 2'd1;
              mode_d = M_IDLE;
            end else if (scount_q >= SCW'(STRING_LIMIT)) begin
              wr_o.res[n] = mk(stt_pkg::TK_ERROR, stt_pkg::ERR_TOO_LONG, tstart_q, sp,
                               line_q);
              n = n + 2'd1;
              mode_d = M_IDLE;
            end else if (byte_q == 8'h5C) begin
              mode_d = M_ESC;
            end else begin
              wr_o.res[n] = mk(stt_pkg::TK_STR_BYTE, 31'(byte_q), off_q, 16'd1, line_q);
              n = n + 2'd1;
              scount_d = scount_q + SCW'(1);
            end
          end
          M_ESC: begin
            tspan_d = sp;
            if (esc_ok) begin
              wr_o.res[n] = mk(stt_pkg::TK_STR_BYTE, 31'(esc), off_q - 32'd1, 16'd2,
                               line_q);
              n = n + 2'd1;
              scount_d = scount_q + SCW'(1);
              mode_d   = M_STR;
            end else begin
              wr_o.res[n] = mk(stt_pkg::TK_ERROR, stt_pkg::ERR_BAD_ESCAPE, tstart_q, sp,
                               line_q);
              n = n + 2'd1;
              mode_d = M_IDLE;
            end
          end
          default: idle_go = 1'b1;
        endcase

        // Byte seen from the idle state
        if (idle_go) begin
          mode_d = M_IDLE;
          if (stt_pkg::is_space(byte_q)) begin
            if (byte_q == 8'h0A && line_q != 32'hFFFF_FFFF) begin
              line_d = line_q + 32'd1;
            end
          end else if (opk != stt_pkg::TK_EOF) begin
            wr_o.res[n] = mk(opk, 31'd0, off_q, 16'd1, line_q);
            n = n + 2'd1;
          end else begin
            tstart_d = off_q;
            tspan_d  = 16'd0;
            if (byte_q == 8'h22) begin
              mode_d   = M_STR;
              scount_d = '0;
              tspan_d  = 16'd1;
            end else if (stt_pkg::is_digit(byte_q)) begin
              mode_d  = M_NUM;
              acc_d   = 31'(byte_q[3:0]);
              tspan_d = 16'd1;
            end else if (stt_pkg::is_alpha(byte_q)) begin
              mode_d  = M_WORD;
              cand_d  = stt_pkg::kw_match(byte_q, 16'd0);
              tspan_d = 16'd1;
            end else begin
              wr_o.res[n] = mk(stt_pkg::TK_ERROR, stt_pkg::ERR_UNEXPECTED, off_q, 16'd1,
                               line_q);
              n = n + 2'd1;
            end
          end
        end
      end
      if (n != 2'd0) begin
        wr_o.res[n - 2'd1].last = 1'b1;
      end
    end
    wr_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      acc_q    <= 31'd0;
      cand_q   <= '1;
      off_q    <= 32'd0;
      line_q   <= 32'd1;
      tstart_q <= 32'd0;
      tspan_q  <= 16'd0;
      scount_q <= '0;
    end else begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      cand_q   <= cand_d;
      off_q    <= off_d;
      line_q   <= line_d;
      tstart_q <= tstart_d;
      tspan_q  <= tspan_d;
      scount_q <= scount_d;
    end
  end

`ifndef SYNTHESIS
  // End of input always yields at least the eof token
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && kind_q) |-> (wr_o.cnt != 2'd0))
    else $error("end of input produced no result");

  // After end of input the stream position restarts
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && kind_q) |=> (off_q == 32'd0 && line_q == 32'd1 && mode_q == M_IDLE))
    else $error("stream position not restarted");

  // Decoded byte count never passes the string limit
  a_scount_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scount_q <= SCW'(STRING_LIMIT))
    else $error("string byte count above limit");
`endif

endmodule

>>> src/stt_result_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Small register queue: up to three in a cycle, one out a cycle if ready.
// ----------------------------------------------------------------------------
module stt_result_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stt_pkg::rq_write_t wr_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stt_pkg::result_t   out_res_o
);

  stt_pkg::result_t         mem_q [stt_pkg::QDEPTH];
  logic [stt_pkg::QAW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [stt_pkg::QAW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [stt_pkg::QCW-1:0]  cnt_q, cnt_d;
  logic                     pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Space for a full burst of three
  assign room_o      = (cnt_q <= stt_pkg::QCW'(stt_pkg::QDEPTH - 3));

  always_comb begin
    wr_ptr_d = wr_ptr_q + stt_pkg::QAW'(wr_i.cnt);
    rd_ptr_d = rd_ptr_q + stt_pkg::QAW'(pop);
    cnt_d    = cnt_q + stt_pkg::QCW'(wr_i.cnt) - stt_pkg::QCW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < wr_i.cnt) begin
        mem_q[wr_ptr_q + stt_pkg::QAW'(i)] <= wr_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stt_pkg::QCW'(stt_pkg::QDEPTH))
    else $error("result queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.cnt != 2'd0) |-> ({2'b00, wr_i.cnt} + cnt_q <= stt_pkg::QCW'(stt_pkg::QDEPTH)))
    else $error("result queue overflow");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i.cnt == 2'd0 && !pop) |=> $stable(cnt_q))
    else $error("result queue count moved without traffic");
`endif

endmodule

>>> src/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Source text tokenizer core
// Streaming lexer: source bytes in, tokens with position and line out.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals             Contents
// s_axis    in   tdata[7:0]          byte_value
//                tuser[0]            kind (0 source byte, 1 end of input)
// m_axis    out  tdata[111:0]        value[30:0], start_offset[62:31],
//                                    span_length[78:63], line_number[110:79],
//                                    zero pad[111]
//                tuser[4:0]          token_kind
//                tlast               last result caused by one input transaction
//
// One input transaction is taken per cycle unless the input side stalls.
// Each accepted byte sits in an input register, is scanned combinationally
// and writes between zero and three results into an eight-entry result
// queue, which drains one result per cycle while the output is ready. The
// input side stalls only while the queue has fewer than three free entries,
// so the drain rate limits sustained throughput when items give bursts.
// Reset is asynchronous and active low; it clears the scan state (offset 0,
// line 1, idle) and empties the queue. No clearing pass is needed.
//
// The scanner keeps a saturating 31-bit number accumulator, a seven-bit set
// of keyword candidates narrowed byte by byte, and a decoded-byte count for
// strings bounded by STRING_LIMIT. Output ordering follows input order
// exactly, since every result passes through the single queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core #(
  parameter int STRING_LIMIT = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic         s_axis_tuser,   // [0] kind
  // Token stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // value, start_offset, span_length, line_number
  output logic [4:0]   m_axis_tuser,   // [4:0] token_kind
  output logic         m_axis_tlast
);

  stt_pkg::rq_write_t wr;
  stt_pkg::result_t   head;
  logic               room;

  // Scanner: input register and token logic
  stt_scanner #(
    .STRING_LIMIT (STRING_LIMIT)
  ) u_scanner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .room_i     (room),
    .wr_o       (wr)
  );

  // Result queue decouples token bursts from the output handshake
  stt_result_queue u_result_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (head)
  );

  // Pack the head result onto the output transaction
  assign m_axis_tdata = {1'b0, head.line_number, head.span_length,
                         head.start_offset, head.value};
  assign m_axis_tuser = head.token_kind;
  assign m_axis_tlast = head.last;

endmodule

>>> sim/stt_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Token stream checker
// Watches both channels of the tokenizer, predicts the tokens for every
// accepted input transaction and compares them in order with the output.
// ----------------------------------------------------------------------------
module stt_token_checker #(
  parameter int STRING_LIMIT = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  input  logic [4:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_o
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam int         MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUM, SCAN_DOT, SCAN_FRAC, SCAN_WORD, SCAN_STR, SCAN_ESC
  } scan_mode_e;

  scan_mode_e  mode;
  logic [30:0] acc;
  logic [6:0]  cand;
  logic [31:0] offs;
  logic [31:0] line_cnt;
  logic [31:0] tok_start;
  logic [15:0] tok_span;
  int          str_count;
  int          shown;

  stt_pkg::result_t tokens_due[$];
  stt_pkg::result_t step_out[$];

  function automatic logic is_num_char(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == " " || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Reserved words in priority order: two booleans, then five keywords.
  function automatic string word_text(input int w);
    case (w)
      0:       return "true";
      1:       return "false";
      2:       return "impl";
      3:       return "if";
      4:       return "else";
      5:       return "while";
      default: return "for";
    endcase
  endfunction

  function automatic logic [4:0] op_token(input logic [7:0] b);
    string ops;
    ops = "+-*/%()=:,{};";
    for (int i = 0; i < ops.len(); i++) begin
      if (ops[i] == b) return stt_pkg::TK_OP_PLUS + 5'(i);
    end
    return stt_pkg::TK_EOF;
  endfunction

  task automatic reset_scan();
    mode      = SCAN_IDLE;
    acc       = '0;
    cand      = '1;
    offs      = '0;
    line_cnt  = 32'd1;
    tok_start = '0;
    tok_span  = '0;
    str_count = 0;
  endtask

  // At most three tokens can come from one transaction.
  task automatic put_token(input logic [4:0] k, input logic [30:0] v,
                           input logic [31:0] st, input logic [15:0] sp);
    stt_pkg::result_t r;
    if (step_out.size() < 3) begin
      r.token_kind   = k;
      r.value        = v;
      r.start_offset = st;
      r.span_length  = sp;
      r.line_number  = line_cnt;
      r.last         = 1'b0;
      step_out.push_back(r);
    end
  endtask

  task automatic span_up();
    if (tok_span != 16'hFFFF) tok_span++;
  endtask

  // Drops every reserved word that does not have byte b at the current position.
  task automatic narrow_words(input logic [7:0] b);
    string s;
    for (int i = 0; i < 7; i++) begin
      s = word_text(i);
      if (tok_span >= s.len() || s[tok_span] != b) cand[i] = 1'b0;
    end
  endtask

  task automatic close_word();
    string s;
    bit    done;
    done = 1'b0;
    for (int i = 0; i < 7; i++) begin
      s = word_text(i);
      if (!done && cand[i] && s.len() == tok_span) begin
        done = 1'b1;
        if (i == 0) put_token(stt_pkg::TK_BOOLEAN, 31'd1, tok_start, tok_span);
        else if (i == 1) put_token(stt_pkg::TK_BOOLEAN, 31'd0, tok_start, tok_span);
        else put_token(stt_pkg::TK_KEYWORD, 31'(i - 2), tok_start, tok_span);
      end
    end
    if (!done) put_token(stt_pkg::TK_IDENT, '0, tok_start, tok_span);
  endtask

  task automatic close_number();
    put_token(stt_pkg::TK_NUMBER, acc, tok_start, tok_span);
  endtask

  task automatic scan_idle(input logic [7:0] b, input logic [31:0] o);
    logic [4:0] k;
    mode = SCAN_IDLE;
    k    = op_token(b);
    if (is_blank(b)) begin
      if (b == CH_NL && line_cnt != '1) line_cnt++;
    end else if (k != stt_pkg::TK_EOF) begin
      put_token(k, '0, o, 16'd1);
    end else begin
      tok_start = o;
      tok_span  = '0;
      if (b == CH_QUOTE) begin
        mode      = SCAN_STR;
        str_count = 0;
        tok_span  = 16'd1;
      end else if (is_num_char(b)) begin
        mode     = SCAN_NUM;
        acc      = 31'(b - CH_ZERO);
        tok_span = 16'd1;
      end else if (is_letter(b)) begin
        mode = SCAN_WORD;
        cand = '1;
        narrow_words(b);
        tok_span = 16'd1;
      end else begin
        put_token(stt_pkg::TK_ERROR, stt_pkg::ERR_UNEXPECTED, o, 16'd1);
      end
    end
  endtask

  task automatic predict_item(input logic kind, input logic [7:0] b);
    logic [31:0]      o;
    logic [31:0]      d;
    logic [31:0]      grown;
    logic [7:0]       dec;
    stt_pkg::result_t r;
    o = offs;
    step_out.delete();
    if (kind) begin
      // End of input flushes the open token, then eof restarts the stream.
      case (mode)
        SCAN_NUM, SCAN_FRAC: close_number();
        SCAN_DOT: begin
          close_number();
          put_token(stt_pkg::TK_ERROR, stt_pkg::ERR_UNEXPECTED, o - 32'd1, 16'd1);
        end
        SCAN_WORD: close_word();
        SCAN_STR, SCAN_ESC: put_token(stt_pkg::TK_ERROR, stt_pkg::ERR_UNTERMINATED,
                                      tok_start, tok_span);
        default: ;
      endcase
      put_token(stt_pkg::TK_EOF, '0, o, '0);
      reset_scan();
    end else begin
      case (mode)
        SCAN_NUM: begin
          if (is_num_char(b)) begin
            d = 32'(b - CH_ZERO);
            if ({1'b0, acc} > (32'(stt_pkg::ACC_MAX) - d) / 32'd10) begin
              acc = stt_pkg::ACC_MAX;
            end else begin
              grown = {1'b0, acc} * 32'd10 + d;
              acc   = grown[30:0];
            end
            span_up();
          end else if (b == CH_DOT) begin
            mode = SCAN_DOT;
          end else begin
            close_number();
            scan_idle(b, o);
          end
        end
        SCAN_DOT: begin
          if (is_num_char(b)) begin
            mode = SCAN_FRAC;
            span_up();
            span_up();
          end else begin
            close_number();
            put_token(stt_pkg::TK_ERROR, stt_pkg::ERR_UNEXPECTED, o - 32'd1, 16'd1);
            scan_idle(b, o);
          end
        end
        SCAN_FRAC: begin
          if (is_num_char(b)) begin
            span_up();
          end else begin
            close_number();
            scan_idle(b, o);
          end
        end
        SCAN_WORD: begin
          if (is_letter(b)) begin
            narrow_words(b);
            span_up();
          end else begin
            close_word();
            scan_idle(b, o);
          end
        end
        SCAN_STR: begin
          span_up();
          if (b == CH_QUOTE) begin
            put_token(stt_pkg::TK_STRING, 31'(str_count), tok_start, tok_span);
            mode = SCAN_IDLE;
          end else if (str_count >= STRING_LIMIT) begin
            put_token(stt_pkg::TK_ERROR, stt_pkg::ERR_TOO_LONG, tok_start, tok_span);
            mode = SCAN_IDLE;
          end else if (b == CH_BSLASH) begin
            mode = SCAN_ESC;
          end else begin
            put_token(stt_pkg::TK_STR_BYTE, 31'(b), o, 16'd1);
            str_count++;
          end
        end
        SCAN_ESC: begin
          span_up();
          dec = 8'h00;
          if (b == "n") dec = CH_NL;
          else if (b == "t") dec = CH_TAB;
          else if (b == CH_QUOTE || b == CH_BSLASH) dec = b;
          if (dec != 8'h00) begin
            put_token(stt_pkg::TK_STR_BYTE, 31'(dec), o - 32'd1, 16'd2);
            str_count++;
            mode = SCAN_STR;
          end else begin
            put_token(stt_pkg::TK_ERROR, stt_pkg::ERR_BAD_ESCAPE, tok_start, tok_span);
            mode = SCAN_IDLE;
          end
        end
        default: scan_idle(b, o);
      endcase
      offs = o + 32'd1;
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) tokens_due.push_back(step_out[i]);
  endtask

  task automatic check_token();
    stt_pkg::result_t got;
    stt_pkg::result_t want;
    got.token_kind   = m_axis_tuser;
    got.value        = m_axis_tdata[30:0];
    got.start_offset = m_axis_tdata[62:31];
    got.span_length  = m_axis_tdata[78:63];
    got.line_number  = m_axis_tdata[110:79];
    got.last         = m_axis_tlast;
    if (tokens_due.size() == 0) begin
      fail_count_o++;
      if (shown < MAX_REPORTS) begin
        shown++;
        $display("unexpected token: kind %0d value %0d start %0d span %0d line %0d last %0b",
                 got.token_kind, got.value, got.start_offset, got.span_length,
                 got.line_number, got.last);
      end
    end else begin
      want = tokens_due.pop_front();
      if (got.token_kind != want.token_kind || got.value != want.value ||
          got.start_offset != want.start_offset || got.span_length != want.span_length ||
          got.line_number != want.line_number || got.last != want.last) begin
        fail_count_o++;
        if (shown < MAX_REPORTS) begin
          shown++;
          $display("token mismatch: expected kind %0d value %0d start %0d span %0d line %0d last %0b",
                   want.token_kind, want.value, want.start_offset, want.span_length,
                   want.line_number, want.last);
          $display("                got      kind %0d value %0d start %0d span %0d line %0d last %0b",
                   got.token_kind, got.value, got.start_offset, got.span_length,
                   got.line_number, got.last);
        end
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    shown        = 0;
    reset_scan();
  end

  // Prediction runs before comparison so that a token can never be judged
  // ahead of the transaction that caused it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_scan();
      tokens_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_token();
    end
    pending_o = tokens_due.size();
  end

endmodule

>>> sim/source_text_tokenizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Feeds the tokenizer with short directed text and then with random token
// soup, stalling both channels at random; a checker alongside predicts and
// compares every token and this top level gives the verdict.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core_tb;

  localparam int         STR_LIMIT    = 64;
  localparam int         RANDOM_ITEMS = 480;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic       KIND_BYTE    = 1'b0;
  localparam logic       KIND_END     = 1'b1;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BSLASH    = 8'h5C;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;

  logic         src_valid = 1'b0;
  logic [7:0]   src_byte  = 8'h00;
  logic         src_kind  = KIND_BYTE;
  logic         s_axis_tready;

  logic         sink_ready = 1'b0;
  int           sink_hold  = 0;
  logic         m_axis_tvalid;
  logic [111:0] m_axis_tdata;
  logic [4:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int           fail_count;
  int           pending;
  int           items_sent = 0;
  int           cycles     = 0;
  bit           src_calm   = 1'b0;
  bit           sink_calm  = 1'b0;
  bit           long_done  = 1'b0;

  always #10 clk_i = ~clk_i;

  source_text_tokenizer_core #(
    .STRING_LIMIT (STR_LIMIT)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (src_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (src_byte),
    .s_axis_tuser  (src_kind),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (sink_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  stt_token_checker #(
    .STRING_LIMIT (STR_LIMIT)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (src_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (src_byte),
    .s_axis_tuser  (src_kind),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (sink_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Token sink. After each accepted token it may draw a random stall, often
  // none; in calm stretches it takes everything at once, so the result queue
  // sees both back pressure and full-rate draining.
  always @(posedge clk_i or negedge rst_ni) begin : sink_side
    int draw;
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      sink_hold  <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      if (sink_hold == 1) sink_ready <= 1'b1;
    end else if (sink_ready && m_axis_tvalid) begin
      if ($urandom_range(0, 39) == 0) sink_calm = ~sink_calm;
      draw = sink_calm ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0);
      if (draw != 0) begin
        sink_ready <= 1'b0;
        sink_hold  <= draw;
      end
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // One input transaction. The gap before it is drawn per item; with no gap
  // the valid simply stays high and only the data changes, so valid never
  // sees two assignments within one time step.
  task automatic send_item(input logic kind, input logic [7:0] b);
    int gap;
    gap = src_calm ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0);
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_valid <= 1'b1;
    src_kind  <= kind;
    src_byte  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_BYTE, s[i]);
  endtask

  // Any byte that a string takes literally, high bytes and control codes too.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic send_digits(input int n);
    repeat (n) send_item(KIND_BYTE, 8'($urandom_range("0", "9")));
  endtask

  // One random lexical element, mostly well formed, with some noise and
  // broken sequences mixed in so that every scanner state is left by every
  // kind of byte.
  task automatic send_random_token();
    int    pick;
    int    n;
    string ops;
    string near;
    ops  = "+-*/%()=:,{};";
    near = "efhilnorstuwEI";
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) src_calm = ~src_calm;
    if (!long_done || pick < 2) begin
      // A string right at the decoded-byte limit: some close in time, the
      // rest overflow it.
      long_done = 1'b1;
      send_item(KIND_BYTE, CH_QUOTE);
      n = $urandom_range(STR_LIMIT - 1, STR_LIMIT + 2);
      repeat (n) send_item(KIND_BYTE, plain_char());
      if ($urandom_range(0, 1) == 0) send_item(KIND_BYTE, CH_QUOTE);
    end else if (pick < 22) begin
      // Long digit runs push the accumulator into saturation.
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
      send_digits(n);
      if ($urandom_range(0, 2) == 0) begin
        send_item(KIND_BYTE, CH_DOT);
        send_digits($urandom_range(0, 3));
      end
    end else if (pick < 42) begin
      case ($urandom_range(0, 9))
        0: send_text("true");
        1: send_text("false");
        2: send_text("impl");
        3: send_text("if");
        4: send_text("else");
        5: send_text("while");
        6: send_text("for");
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) send_item(KIND_BYTE, near[$urandom_range(0, near.len() - 1)]);
        end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        send_item(KIND_BYTE, 8'($urandom_range(0, 1) ? $urandom_range("a", "z")
                                                     : $urandom_range("A", "Z")));
      end
    end else if (pick < 58) begin
      send_item(KIND_BYTE, CH_QUOTE);
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            send_item(KIND_BYTE, CH_BSLASH);
            case ($urandom_range(0, 3))
              0:       send_item(KIND_BYTE, "n");
              1:       send_item(KIND_BYTE, "t");
              2:       send_item(KIND_BYTE, CH_QUOTE);
              default: send_item(KIND_BYTE, CH_BSLASH);
            endcase
          end
          3: begin
            // Mostly a broken escape.
            send_item(KIND_BYTE, CH_BSLASH);
            send_item(KIND_BYTE, 8'($urandom_range("0", "m")));
          end
          default: send_item(KIND_BYTE, plain_char());
        endcase
      end
      if ($urandom_range(0, 9) != 0) send_item(KIND_BYTE, CH_QUOTE);
    end else if (pick < 74) begin
      send_item(KIND_BYTE, ops[$urandom_range(0, ops.len() - 1)]);
    end else if (pick < 84) begin
      send_item(KIND_BYTE, ($urandom_range(0, 5) == 0) ? CH_SPACE
                                                       : 8'($urandom_range(9, 13)));
    end else if (pick < 93) begin
      send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      send_item(KIND_END, 8'($urandom_range(0, 255)));
    end else begin
      send_item(KIND_BYTE, CH_NL);
    end
    if ($urandom_range(0, 1) == 0) send_item(KIND_BYTE, $urandom_range(0, 3) ? CH_SPACE : CH_NL);
  endtask

  // Watchdog: the slowest correct run is far below this bound.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed text: a boolean, a number whose dot meets an operator (three
    // tokens from one transaction), a string with a good and a bad escape,
    // the two extreme byte values as unexpected characters, a newline, a
    // number with a skipped fraction running into a string, and end of input
    // inside that string.
    send_text("true 9.;");
    send_text("\"a\\t\\q");
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_text("\n3.14\"z");
    send_item(KIND_END, 8'hA5);

    n_loop: while (items_sent < RANDOM_ITEMS + 24) send_random_token();

    // A final end marker flushes whatever token is still open.
    send_item(KIND_END, 8'($urandom_range(0, 255)));
    src_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
